// ----- src/idp_pkg.sv -----
// Package for the image difference / PSNR meter: shared types and constants.
// No dependencies.
package idp_pkg;

    localparam logic [23:0] PEAK_SQ_Q8 = 24'd16646400;
    localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
    localparam logic [14:0] PSNR_MAX = 15'd32767;

    // One sample pair after classification in the front part
    typedef struct packed {
        logic signed [8:0] diff;
        logic              counted;
        logic              last;
    } idp_item_t;

    // Result item
    typedef struct packed {
        logic                psnr_infinite;
        logic [14:0]         psnr_db;
        logic [23:0]         mean_square_error;
        logic signed [16:0]  mean_error;
        logic                stats_valid;
        logic [7:0]          diff_pixel;
    } idp_result_t;

endpackage

// ----- src/image_difference_psnr_top.sv -----
// Top level of the image difference / PSNR meter.
// Depends on idp_pkg, idp_front, idp_queue, idp_back.
//
// channel   | dir | contents
// s_axis    | in  | tdata: pixel_a[7:0], pixel_b[15:8]; tlast: last_sample
// m_axis    | out | tdata: diff_pixel[7:0], mean_error[24:8],
//           |     |        mean_square_error[48:25], psnr_db[63:49]
//           |     | tuser: psnr_infinite; tlast: stats_valid
// cfg       | in  | cfg_data: pixel offset
//
// Ordinary samples pass at one per cycle while the output is accepted. On a
// last sample the back part runs the two serial divisions, 32 log2 squaring
// steps (16 when the MSE is zero, with no scaling), a scaling step and an
// output step before it takes the next sample. The front register and the
// two-entry queue absorb three samples meanwhile, then the input stalls; a held
// result stalls the back part. Reset puts the pixel offset at 128 and clears the sums.
module image_difference_psnr_top #(
    parameter int MAX_SAMPLES_LOG2 = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_a, pixel_b
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // diff_pixel, mean_error, mean_square_error, psnr_db
    output logic        m_axis_tuser,   // psnr_infinite
    output logic        m_axis_tlast,   // stats_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import idp_pkg::*;

    logic [7:0]  offset_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    idp_item_t   f_item, b_item;
    logic [7:0]  f_pixel, b_pixel;
    idp_result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= 8'd128;
        else if (cfg_valid && cfg_ready)
            offset_reg <= cfg_data;
    end

    idp_front #(.MAX_SAMPLES_LOG2(MAX_SAMPLES_LOG2)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .pixel_a(s_axis_tdata[7:0]), .pixel_b(s_axis_tdata[15:8]),
        .last_sample(s_axis_tlast), .pix_offset(offset_reg),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item), .q_pixel(f_pixel)
    );

    idp_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item), .in_pixel(f_pixel),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item), .out_pixel(b_pixel)
    );

    idp_back #(.MAX_SAMPLES_LOG2(MAX_SAMPLES_LOG2)) u_back (
        .clk, .rst_n,
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item), .q_pixel(b_pixel),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
    );

    assign m_axis_tdata = {res.psnr_db, res.mean_square_error,
                           res.mean_error, res.diff_pixel};
    assign m_axis_tuser = res.psnr_infinite;
    assign m_axis_tlast = res.stats_valid;
endmodule

// ----- src/idp_front.sv -----
// Front part: accepts sample pairs, forms the difference pixel, tracks the
// sample count limit. Depends on idp_pkg.
module idp_front #(
    parameter int MAX_SAMPLES_LOG2 = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          pixel_a,
    input  logic [7:0]          pixel_b,
    input  logic                last_sample,
    input  logic [7:0]          pix_offset,
    output logic                q_valid,
    input  logic                q_ready,
    output idp_pkg::idp_item_t  q_item,
    output logic [7:0]          q_pixel
);
    import idp_pkg::*;

    localparam int CW = MAX_SAMPLES_LOG2 + 1;

    logic [CW-1:0]     count_reg, count_next;
    logic              full_reg;
    idp_item_t         item_reg;
    logic [7:0]        pixel_reg;
    logic signed [8:0] d;
    logic signed [10:0] px;
    logic              take;
    logic              cnt_ok;

    assign in_ready = !full_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign d        = $signed({1'b0, pixel_a}) - $signed({1'b0, pixel_b});
    assign px       = 11'(d >>> 1) + $signed({3'b000, pix_offset});
    assign cnt_ok   = count_reg < (CW'(1) << MAX_SAMPLES_LOG2);

    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            if (last_sample)
                count_next = '0;
            else if (cnt_ok)
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
                full_reg <= 1'b1;
            else if (q_ready)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.diff    <= d;
            item_reg.counted <= cnt_ok;
            item_reg.last    <= last_sample;
            if (px < 0)
                pixel_reg <= 8'd0;
            else if (px > 11'sd255)
                pixel_reg <= 8'd255;
            else
                pixel_reg <= px[7:0];
        end
    end

    assign q_valid = full_reg;
    assign q_item  = item_reg;
    assign q_pixel = pixel_reg;
endmodule

// ----- src/idp_queue.sv -----
// Short queue between front and back parts (two entries).
// Depends on idp_pkg.
module idp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  idp_pkg::idp_item_t  in_item,
    input  logic [7:0]          in_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output idp_pkg::idp_item_t  out_item,
    output logic [7:0]          out_pixel
);
    import idp_pkg::*;

    idp_item_t  item_mem [2];
    logic [7:0] pix_mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = item_mem[rp_reg];
    assign out_pixel = pix_mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wp_reg] <= in_item;
            pix_mem[wp_reg]  <= in_pixel;
        end
    end
endmodule

// ----- src/idp_back.sv -----
// Back part: accumulates sums, and at frame end runs serial divisions and
// the iterative log2, then presents the result. Depends on idp_pkg.
module idp_back #(
    parameter int MAX_SAMPLES_LOG2 = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  idp_pkg::idp_item_t   q_item,
    input  logic [7:0]           q_pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output idp_pkg::idp_result_t out_data
);
    import idp_pkg::*;

    localparam int CW = MAX_SAMPLES_LOG2 + 1;
    localparam int EW = MAX_SAMPLES_LOG2 + 10;
    localparam int SW = MAX_SAMPLES_LOG2 + 16;
    localparam int NW = SW + 8;         // numerator width of mse division
    localparam int QW = NW;             // quotient width

    typedef enum logic [2:0] {
        S_RUN, S_DIV_ME, S_DIV_MSE, S_LOG_P, S_LOG_M, S_SCALE, S_OUT
    } state_t;

    state_t                state_reg;
    logic signed [EW-1:0]  esum_reg;
    logic [SW-1:0]         ssum_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg;
    logic [NW-1:0]         num_reg;
    logic [CW:0]           rem_reg;
    logic [QW-1:0]         quo_reg;
    logic [5:0]            bit_reg;
    logic [16:0]           me_reg;
    logic [23:0]           mse_reg;
    logic                  big_reg;
    logic [31:0]           y_reg;
    logic [21:0]           lg_reg;
    logic [21:0]           lp_reg;
    logic [3:0]            it_reg;
    logic [39:0]           prod_reg;
    idp_result_t           res_reg;
    logic                  oval_reg, oval_next;

    logic signed [EW-1:0]  esum_a;
    logic [SW-1:0]         ssum_a;
    logic [CW-1:0]         cnt_a;
    logic [17:0]           dsq;
    logic [EW-1:0]         mag;
    logic [CW:0]           rem_sh;
    logic [CW:0]           rem_sub;
    logic                  ge;
    logic [QW-1:0]         quo_fin;
    logic [63:0]           ysq;
    logic [33:0]           ynew;
    logic                  sq_hit;
    logic [21:0]           lg_step;
    logic [4:0]            msb;
    logic [21:0]           dl;
    logic [14:0]           psnr_w;
    logic [15:0]           prod_hi;
    idp_result_t           run_res;
    idp_result_t           fin_res;
    logic                  take, oslot;

    assign oslot   = !oval_reg || out_ready;
    assign q_ready = (state_reg == S_RUN) && oslot;
    assign take    = q_valid && q_ready;
    assign dsq     = $signed(q_item.diff) * $signed(q_item.diff);

    always_comb
    begin
        esum_a = esum_reg;
        ssum_a = ssum_reg;
        cnt_a  = cnt_reg;
        if (q_item.counted)
        begin
            esum_a = esum_reg + EW'($signed(q_item.diff));
            ssum_a = ssum_reg + SW'(dsq);
            cnt_a  = cnt_reg + CW'(1);
        end
    end

    assign mag     = esum_a[EW-1] ? EW'(-esum_a) : EW'(esum_a);
    assign rem_sh  = {rem_reg[CW-1:0], num_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, cnt_reg};
    assign rem_sub = rem_sh - {1'b0, cnt_reg};
    assign quo_fin = {quo_reg[QW-2:0], ge};

    assign ysq     = 64'(y_reg) * 64'(y_reg);
    assign ynew    = ysq[63:30];
    assign sq_hit  = ynew[31] || ynew[32] || ynew[33];
    assign lg_step = sq_hit ? (lg_reg | (22'd1 << it_reg)) : lg_reg;

    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 24; i++)
            if (mse_reg[i])
                msb = 5'(i);
    end

    assign dl      = (lp_reg > lg_reg) ? lp_reg - lg_reg : 22'd0;
    assign prod_hi = prod_reg[39:24];
    assign psnr_w  = (prod_hi > 16'(PSNR_MAX)) ? PSNR_MAX : prod_hi[14:0];

    always_comb
    begin
        oval_next = oval_reg && !out_ready;
        if (take && !q_item.last)
            oval_next = 1'b1;
        if (state_reg == S_OUT && oslot)
            oval_next = 1'b1;
    end

    always_comb
    begin
        run_res            = '0;
        run_res.diff_pixel = q_pixel;
    end

    always_comb
    begin
        fin_res                   = res_reg;
        fin_res.stats_valid       = 1'b1;
        fin_res.mean_error        = $signed(me_reg);
        fin_res.mean_square_error = mse_reg;
        fin_res.psnr_infinite     = !big_reg;
        fin_res.psnr_db           = big_reg ? psnr_w : PSNR_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            esum_reg  <= '0;
            ssum_reg  <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            num_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            bit_reg   <= '0;
            me_reg    <= '0;
            mse_reg   <= '0;
            big_reg   <= 1'b0;
            y_reg     <= '0;
            lg_reg    <= '0;
            lp_reg    <= '0;
            it_reg    <= '0;
            prod_reg  <= '0;
            res_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            oval_reg <= oval_next;
            case (state_reg)
                S_RUN:
                begin
                    if (take)
                    begin
                        res_reg <= run_res;
                        if (q_item.last)
                        begin
                            cnt_reg  <= cnt_a;
                            ssum_reg <= ssum_a;
                            esum_reg <= '0;
                            neg_reg  <= esum_a[EW-1];
                            // numerator mag*256 + n/2, aligned to the top
                            num_reg  <= NW'({mag, 8'd0} + EW'(cnt_a >> 1)) <<
                                        (NW - EW - 8);
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            bit_reg  <= 6'(EW + 8 - 1);
                            state_reg <= S_DIV_ME;
                        end
                        else
                        begin
                            esum_reg <= esum_a;
                            ssum_reg <= ssum_a;
                            cnt_reg  <= cnt_a;
                        end
                    end
                end
                S_DIV_ME, S_DIV_MSE:
                begin
                    if (bit_reg != 6'd0)
                    begin
                        num_reg <= num_reg << 1;
                        rem_reg <= ge ? rem_sub : rem_sh;
                        quo_reg <= quo_fin;
                        bit_reg <= bit_reg - 6'd1;
                    end
                    else if (state_reg == S_DIV_ME)
                    begin
                        me_reg   <= neg_reg ? 17'(-quo_fin) : 17'(quo_fin);
                        num_reg  <= NW'({ssum_reg, 8'd0}) + NW'(cnt_reg >> 1);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= 6'(NW - 1);
                        state_reg <= S_DIV_MSE;
                    end
                    else
                    begin
                        mse_reg  <= 24'(quo_fin);
                        big_reg  <= 1'b0;
                        // log2 of the peak first
                        y_reg    <= 32'(PEAK_SQ_Q8) << 7;
                        lg_reg   <= 22'(23) << 16;
                        it_reg   <= 4'd15;
                        state_reg <= S_LOG_P;
                    end
                end
                S_LOG_P, S_LOG_M:
                begin
                    if (it_reg != 4'd0)
                    begin
                        y_reg  <= sq_hit ? ynew[32:1] : ynew[31:0];
                        lg_reg <= lg_step;
                        it_reg <= it_reg - 4'd1;
                    end
                    else if (state_reg == S_LOG_P)
                    begin
                        lp_reg <= lg_step;
                        y_reg  <= 32'(mse_reg) << (5'd30 - msb);
                        lg_reg <= 22'(msb) << 16;
                        it_reg <= 4'd15;
                        state_reg <= (mse_reg == 24'd0) ? S_OUT : S_LOG_M;
                    end
                    else
                    begin
                        lg_reg    <= lg_step;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    prod_reg  <= 40'(dl) * 40'(TEN_LOG10_2_Q16) + (40'd1 << 23);
                    big_reg   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (oslot)
                    begin
                        res_reg   <= fin_res;
                        cnt_reg   <= '0;
                        ssum_reg  <= '0;
                        state_reg <= S_RUN;
                    end
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end

    assign out_valid = oval_reg;
    assign out_data  = res_reg;
endmodule
